// ===== hw/rtl/btuid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btuid_pkg
// Types, constants and helper functions for the bearer token user id extractor.
// ----------------------------------------------------------------------------
package btuid_pkg;

  localparam int unsigned PrefixLen = 7;

  localparam logic [7:0] BEARER_TEXT [PrefixLen] = '{
    8'h62, 8'h65, 8'h61, 8'h72, 8'h65, 8'h72, 8'h20
  };

  localparam logic [7:0] UID_KEY [3] = '{8'h75, 8'h69, 8'h64};
  localparam logic [7:0] SUB_KEY [3] = '{8'h73, 8'h75, 8'h62};

  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0a;

  // matcher phases
  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_KEY0   = 3'd1;
  localparam logic [2:0] PH_KEY1   = 3'd2;
  localparam logic [2:0] PH_KEY2   = 3'd3;
  localparam logic [2:0] PH_CLOSE  = 3'd4;
  localparam logic [2:0] PH_COLON  = 3'd5;
  localparam logic [2:0] PH_DIGITS = 3'd6;
  localparam logic [2:0] PH_DONE   = 3'd7;

  // id source codes
  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_UID  = 2'd1;
  localparam logic [1:0] SRC_SUB  = 2'd2;

  typedef struct packed {
    logic [2:0]  phase;
    logic [63:0] value;
    logic        has_digit;
  } matcher_t;

  // bit 6 flags a valid base64url character, bits 5:0 hold the sextet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5a)      r = {1'b1, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7a) r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    else if (c == 8'h2d)               r = {1'b1, 6'd62};
    else if (c == 8'h5f)               r = {1'b1, 6'd63};
    return r;
  endfunction

  function automatic matcher_t feed_matcher(input matcher_t m, input logic [7:0] k0,
                                            input logic [7:0] k1, input logic [7:0] k2,
                                            input logic [7:0] c);
    matcher_t   r;
    logic [7:0] want;
    r = m;
    want = k0;
    case (m.phase)
      PH_KEY1: want = k1;
      PH_KEY2: want = k2;
      default: want = k0;
    endcase
    case (m.phase)
      PH_SEARCH: begin
        if (c == CH_QUOTE) r.phase = PH_KEY0;
      end
      PH_KEY0, PH_KEY1, PH_KEY2: begin
        if (c == want)          r.phase = m.phase + 3'd1;
        else if (c == CH_QUOTE) r.phase = PH_KEY0;
        else                    r.phase = PH_SEARCH;
      end
      PH_CLOSE: begin
        r.phase = (c == CH_QUOTE) ? PH_COLON : PH_SEARCH;
      end
      PH_COLON: begin
        if (c == CH_COLON) r.phase = PH_DIGITS;
      end
      PH_DIGITS: begin
        if (c >= 8'h30 && c <= 8'h39) begin
          // times ten plus digit, wraps at 64 bits
          r.value = (m.value << 3) + (m.value << 1) + {60'd0, c[3:0]};
          r.has_digit = 1'b1;
        end else if (c == CH_COMMA || c == CH_RBRACE || c == CH_SPACE || c == CH_LF) begin
          r.phase = PH_DONE;
        end else if (c == CH_QUOTE) begin
          r.value = 64'd0;
          r.phase = PH_DONE;
        end
      end
      default: r = m;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/bearer_token_user_id_extract.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bearer_token_user_id_extract
// Checks the bearer prefix, decodes the claims segment of the token and picks
// out the uid or sub claim as a user id, one result per header value.
// ----------------------------------------------------------------------------
// the last byte passes through the input register, then into the result register
// throughput: one header byte per cycle, set by the single pass from the input
//   register through decode, matcher and times-ten add to the state registers
// a result waiting on the output holds back only a following last byte
// reset: asynchronous, active low; returns all parsing state to the start
//   of a header value and empties both registers
module bearer_token_user_id_extract
  import btuid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] header_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [62:0] user_id, [63] zero
  output logic [1:0]  m_axis_tuser_o    // [1:0] id_source
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // parsing state
  logic [2:0]  prefix_pos_q, prefix_pos_d;
  logic        prefix_good_q, prefix_good_d;
  logic [1:0]  dots_q, dots_d;
  logic [13:0] bit_buf_q, bit_buf_d;
  logic [3:0]  bit_cnt_q, bit_cnt_d;
  matcher_t    uid_q, uid_d, sub_q, sub_d;

  // result register
  logic        out_valid_q;
  logic [62:0] out_id_q, out_id_d;
  logic [1:0]  out_src_q, out_src_d;

  logic        advance;
  logic [7:0]  lc;
  logic [6:0]  sextet;
  logic [13:0] buf_new;
  logic [3:0]  cnt_sum;
  logic [3:0]  cnt_new;
  logic [13:0] buf_shift;
  logic [2:0]  pos_n;
  logic        good_n;
  logic [1:0]  dots_n;
  matcher_t    uid_n, sub_n;

  // a last byte waits while the result register is still full
  assign advance = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    lc = in_byte_q;
    if (in_byte_q >= 8'h41 && in_byte_q <= 8'h5a) lc = in_byte_q | 8'h20;
    sextet    = sextet_of(in_byte_q);
    buf_new   = {bit_buf_q[7:0], sextet[5:0]};
    cnt_sum   = bit_cnt_q + 4'd6;
    cnt_new   = cnt_sum - 4'd8;
    buf_shift = buf_new >> cnt_new;

    pos_n  = prefix_pos_q;
    good_n = prefix_good_q;
    dots_n = dots_q;
    bit_buf_d = bit_buf_q;
    bit_cnt_d = bit_cnt_q;
    uid_n  = uid_q;
    sub_n  = sub_q;

    if (prefix_good_q) begin
      if (prefix_pos_q < 3'(PrefixLen)) begin
        if (lc != BEARER_TEXT[prefix_pos_q]) good_n = 1'b0;
        else pos_n = prefix_pos_q + 3'd1;
      end else if (dots_q < 2'd2) begin
        if (in_byte_q == CH_DOT) begin
          dots_n = dots_q + 2'd1;
        end else if (dots_q == 2'd1 && sextet[6]) begin
          bit_buf_d = buf_new;
          if (cnt_sum >= 4'd8) begin
            bit_cnt_d = cnt_new;
            uid_n = feed_matcher(uid_q, UID_KEY[0], UID_KEY[1], UID_KEY[2], buf_shift[7:0]);
            sub_n = feed_matcher(sub_q, SUB_KEY[0], SUB_KEY[1], SUB_KEY[2], buf_shift[7:0]);
          end else begin
            bit_cnt_d = cnt_sum;
          end
        end
      end
    end

    out_id_d  = 63'd0;
    out_src_d = SRC_NONE;
    if (good_n && pos_n == 3'(PrefixLen) && dots_n == 2'd2) begin
      if (uid_n.has_digit && uid_n.value != 64'd0 && !uid_n.value[63]) begin
        out_id_d  = uid_n.value[62:0];
        out_src_d = SRC_UID;
      end else if (sub_n.has_digit && sub_n.value != 64'd0 && !sub_n.value[63]) begin
        out_id_d  = sub_n.value[62:0];
        out_src_d = SRC_SUB;
      end
    end

    prefix_pos_d  = pos_n;
    prefix_good_d = good_n;
    dots_d        = dots_n;
    uid_d         = uid_n;
    sub_d         = sub_n;
    // the last byte starts the next header value from scratch
    if (in_last_q) begin
      prefix_pos_d  = 3'd0;
      prefix_good_d = 1'b1;
      dots_d        = 2'd0;
      bit_buf_d     = 14'd0;
      bit_cnt_d     = 4'd0;
      uid_d         = '{phase: PH_SEARCH, value: 64'd0, has_digit: 1'b0};
      sub_d         = '{phase: PH_SEARCH, value: 64'd0, has_digit: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      prefix_pos_q  <= 3'd0;
      prefix_good_q <= 1'b1;
      dots_q        <= 2'd0;
      bit_buf_q     <= 14'd0;
      bit_cnt_q     <= 4'd0;
      uid_q         <= '{phase: PH_SEARCH, value: 64'd0, has_digit: 1'b0};
      sub_q         <= '{phase: PH_SEARCH, value: 64'd0, has_digit: 1'b0};
      out_valid_q   <= 1'b0;
    end else begin
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (advance) begin
        prefix_pos_q  <= prefix_pos_d;
        prefix_good_q <= prefix_good_d;
        dots_q        <= dots_d;
        bit_buf_q     <= bit_buf_d;
        bit_cnt_q     <= bit_cnt_d;
        uid_q         <= uid_d;
        sub_q         <= sub_d;
      end
      if (advance && in_last_q) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (advance && in_last_q) begin
      out_id_q  <= out_id_d;
      out_src_q <= out_src_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_id_q};
  assign m_axis_tuser_o  = out_src_q;

endmodule

// ===== hw/rtl/btuid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btuid_checker
// Port level checks for the bearer token user id extractor.
// ----------------------------------------------------------------------------
module btuid_checker
  import btuid_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  // a stalled result transfer keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // with the output empty the input side never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == SRC_NONE || m_axis_tuser_o == SRC_UID ||
                         m_axis_tuser_o == SRC_SUB) && !m_axis_tdata_o[63])
    else $error("bad id source or top bit set");

  // no source exactly when the id is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tuser_o == SRC_NONE) == (m_axis_tdata_o == 64'd0)))
    else $error("id and source disagree");

  logic unused_in;
  assign unused_in = s_axis_tvalid_i ^ s_axis_tlast_i ^ (^s_axis_tdata_i);

endmodule

bind bearer_token_user_id_extract btuid_checker u_btuid_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bearer token user id extractor: header values
// go in a byte at a time, and every returned user id and source is compared
// with a row's typed answer or with a cycle-free software copy of the parser.
// ----------------------------------------------------------------------------
module tb;
  import btuid_pkg::*;

  typedef struct packed {
    logic [62:0] user_id;
    logic [1:0]  src;
  } id_result_t;

  typedef struct {
    string       head;
    string       claims;   // plain text, base64url-encoded when sent
    string       tail;
    bit          typed;
    logic [62:0] user_id;
    logic [1:0]  src;
  } claim_row_t;

  localparam logic [23:0] UidWord = {UID_KEY[0], UID_KEY[1], UID_KEY[2]};
  localparam logic [23:0] SubWord = {SUB_KEY[0], SUB_KEY[1], SUB_KEY[2]};
  localparam int NumRows = 22;

  // typed rows carry their own answer, the rest go through the parser copy
  claim_row_t dir_rows [NumRows] = '{
    '{"Basic ", "{\"uid\":5}", ".x", 1'b1, 63'd0, SRC_NONE},
    '{"Bear", "", "", 1'b1, 63'd0, SRC_NONE},
    '{"x", "", "", 1'b1, 63'd0, SRC_NONE},
    '{"bearer abc", "", "", 1'b1, 63'd0, SRC_NONE},
    '{"Bearer h.", "{\"uid\":42}", "", 1'b1, 63'd0, SRC_NONE},
    '{"BEARER h.", "{\"uid\":42}", ".s", 1'b1, 63'd42, SRC_UID},
    '{"bEaReR .", "{\"sub\":77}", ".", 1'b1, 63'd77, SRC_SUB},
    '{"Bearer h.", "{\"uid\":1}", ".s", 1'b1, 63'd1, SRC_UID},
    '{"Bearer h.", "{\"uid\":0,\"sub\":5}", ".sig", 1'b1, 63'd5, SRC_SUB},
    '{"Bearer h.", "{\"uid\":9223372036854775807}", ".s", 1'b1,
      63'h7fff_ffff_ffff_ffff, SRC_UID},
    '{"Bearer h.", "{\"uid\":9223372036854775808,\"sub\":3}", ".s", 1'b1,
      63'd3, SRC_SUB},
    '{"Bearer h.", "{\"uid\":18446744073709551617}", ".s", 1'b1, 63'd1, SRC_UID},
    '{"Bearer h.", "{\"sub\":\"99\"}", ".s", 1'b1, 63'd0, SRC_NONE},
    '{"Bearer h.", "{\"uid\":7}", ".a.b\"uid\":9", 1'b0, 63'd0, SRC_NONE},
    '{"Bearer h.", "{\"uid\" x, \"sub\":8}", ".s", 1'b0, 63'd0, SRC_NONE},
    '{"Bearer h.", "{\"uid\":,\"sub\":12}", ".s", 1'b0, 63'd0, SRC_NONE},
    '{"Bearer h.", "{\"uid\":1a2 }", ".s", 1'b0, 63'd0, SRC_NONE},
    '{"Bearer h.", "{\"UID\":3,\"sub\":4}", ".s", 1'b0, 63'd0, SRC_NONE},
    '{"Bearer h.", "{\"\"uid\":6}", ".s", 1'b0, 63'd0, SRC_NONE},
    '{"Bearer h.", "{\"uid\":88", "==.s", 1'b0, 63'd0, SRC_NONE},
    '{"Bearer h.", "{\"uid\":-4,\n\"sub\":0}", ".s", 1'b0, 63'd0, SRC_NONE},
    '{"Bearer h.!~ ", "{\"sub\":31}", "\n.s", 1'b0, 63'd0, SRC_NONE}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'd0;    // [7:0] header_byte
  logic        s_axis_tlast_i = 1'b0;    // last_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;           // [62:0] user_id, [63] zero
  logic [1:0]  m_axis_tuser_o;           // [1:0] id_source

  // parser copy state
  logic [2:0]  pfx_pos;
  bit          pfx_ok;
  logic [1:0]  ndots;
  logic [13:0] sx_buf;
  logic [3:0]  sx_bits;
  matcher_t    uid_m;
  matcher_t    sub_m;

  id_result_t  pending_ids [$];
  id_result_t  typed_result;
  bit          use_typed;
  logic [7:0]  hdr [$];
  int          snd_idle_pct;
  int          rcv_idle_pct;
  int          rcv_hold;
  int          mismatches;

  bearer_token_user_id_extract i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int sextet_code(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c - "A");
    if (c >= "a" && c <= "z") return int'(c - "a") + 26;
    if (c >= "0" && c <= "9") return int'(c - "0") + 52;
    if (c == "-") return 62;
    if (c == "_") return 63;
    return -1;
  endfunction

  function automatic logic [7:0] sextet_char(input int v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return "-";
    return "_";
  endfunction

  function automatic matcher_t advance_claim(input matcher_t m, input logic [23:0] key,
                                             input logic [7:0] c);
    matcher_t   n;
    logic [7:0] want;
    n = m;
    want = key[23:16];
    if (m.phase == PH_KEY1) want = key[15:8];
    if (m.phase == PH_KEY2) want = key[7:0];
    case (m.phase)
      PH_SEARCH: if (c == CH_QUOTE) n.phase = PH_KEY0;
      PH_KEY0, PH_KEY1, PH_KEY2: begin
        if (c == want)          n.phase = m.phase + 3'd1;
        else if (c == CH_QUOTE) n.phase = PH_KEY0;
        else                    n.phase = PH_SEARCH;
      end
      PH_CLOSE: n.phase = (c == CH_QUOTE) ? PH_COLON : PH_SEARCH;
      PH_COLON: if (c == CH_COLON) n.phase = PH_DIGITS;
      PH_DIGITS: begin
        if (c >= "0" && c <= "9") begin
          n.value = m.value * 64'd10 + 64'(c - "0");
          n.has_digit = 1'b1;
        end else if (c == CH_COMMA || c == CH_RBRACE || c == CH_SPACE || c == CH_LF) begin
          n.phase = PH_DONE;
        end else if (c == CH_QUOTE) begin
          n.value = 64'd0;
          n.phase = PH_DONE;
        end
      end
      default: ;
    endcase
    return n;
  endfunction

  task automatic clear_parse_state();
    pfx_pos = 3'd0;
    pfx_ok  = 1'b1;
    ndots   = 2'd0;
    sx_buf  = 14'd0;
    sx_bits = 4'd0;
    uid_m   = '0;
    sub_m   = '0;
  endtask

  // advance the parser copy by one accepted byte, queue the answer on a last byte
  task automatic take_header_byte(input logic [7:0] c, input bit last);
    logic [7:0] lc;
    logic [7:0] dec;
    int         sx;
    id_result_t r;
    if (pfx_ok) begin
      if (pfx_pos < PrefixLen) begin
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (lc != BEARER_TEXT[pfx_pos]) pfx_ok = 1'b0;
        else pfx_pos = pfx_pos + 3'd1;
      end else if (ndots < 2'd2) begin
        if (c == CH_DOT) begin
          ndots = ndots + 2'd1;
        end else if (ndots == 2'd1) begin
          sx = sextet_code(c);
          if (sx >= 0) begin
            sx_buf = {sx_buf[7:0], sx[5:0]};
            sx_bits = sx_bits + 4'd6;
            if (sx_bits >= 4'd8) begin
              sx_bits = sx_bits - 4'd8;
              dec = 8'(sx_buf >> sx_bits);
              uid_m = advance_claim(uid_m, UidWord, dec);
              sub_m = advance_claim(sub_m, SubWord, dec);
            end
          end
        end
      end
    end
    if (last) begin
      r = '0;
      r.src = SRC_NONE;
      if (pfx_ok && pfx_pos == PrefixLen && ndots == 2'd2) begin
        if (uid_m.has_digit && uid_m.value != 64'd0 && !uid_m.value[63]) begin
          r.user_id = uid_m.value[62:0];
          r.src = SRC_UID;
        end else if (sub_m.has_digit && sub_m.value != 64'd0 && !sub_m.value[63]) begin
          r.user_id = sub_m.value[62:0];
          r.src = SRC_SUB;
        end
      end
      pending_ids.insert(pending_ids.size(), use_typed ? typed_result : r);
      clear_parse_state();
    end
  endtask

  // append one byte to the header under construction
  function automatic void put_hdr(input logic [7:0] b);
    hdr.insert(hdr.size(), b);
  endfunction

  function automatic void add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) put_hdr(s[i]);
  endfunction

  // base64url without padding, with an optional sprinkle of stray bytes
  function automatic void add_b64(input string s, input int noise_pct);
    int          i;
    int          k;
    int          n;
    int          nch;
    logic [23:0] grp;
    logic [7:0]  junk;
    n = s.len();
    for (i = 0; i < n; i += 3) begin
      grp = {s[i], (i + 1 < n) ? s[i + 1] : 8'h00, (i + 2 < n) ? s[i + 2] : 8'h00};
      nch = (n - i >= 3) ? 4 : n - i + 1;
      for (k = 0; k < nch; k++) begin
        if ($urandom_range(99) < noise_pct) begin
          junk = 8'($urandom_range(255));
          put_hdr((junk == CH_DOT) ? 8'h21 : junk);
        end
        put_hdr(sextet_char(int'(grp[23 - 6 * k -: 6])));
      end
    end
  endfunction

  function automatic string random_claims();
    string s;
    int    k;
    int    n;
    int    d;
    int    len;
    s = "{";
    n = $urandom_range(1, 3);
    for (k = 0; k < n; k++) begin
      if (k > 0) begin
        case ($urandom_range(2))
          0: s = {s, ","};
          1: s = {s, ", "};
          default: s = {s, ",\n"};
        endcase
      end
      case ($urandom_range(7))
        0, 1: s = {s, "\"uid\""};
        2, 3: s = {s, "\"sub\""};
        4: s = {s, "\"ui\""};
        5: s = {s, "\"Sub\""};
        6: s = {s, "\"iat\""};
        default: s = {s, "\"\"uid\""};
      endcase
      if ($urandom_range(9) != 0) s = {s, ":"};
      len = 0;
      case ($urandom_range(5))
        0: s = {s, "\"ab\""};
        1: len = $urandom_range(18, 21);   // reaches wrap and the top bit
        2: s = {s, "0"};
        3: s = {s, $sformatf("%0dx%0d", $urandom_range(99), $urandom_range(9))};
        default: len = $urandom_range(1, 6);
      endcase
      for (d = 0; d < len; d++) s = {s, $sformatf("%0d", $urandom_range(9))};
    end
    if ($urandom_range(4) != 0) s = {s, "}"};
    return s;
  endfunction

  task automatic build_random_header();
    int         kind;
    int         i;
    int         n;
    logic [7:0] b;
    hdr.delete();
    kind = $urandom_range(99);
    if (kind < 10) begin
      // plain noise, any byte value
      n = $urandom_range(1, 16);
      for (i = 0; i < n; i++) put_hdr(8'($urandom_range(255)));
    end else begin
      for (i = 0; i < PrefixLen; i++) begin
        b = BEARER_TEXT[i];
        if (b != CH_SPACE && $urandom_range(1) == 1) b = b - 8'd32;
        put_hdr(b);
      end
      if (kind < 20) hdr[$urandom_range(PrefixLen - 1)] = 8'($urandom_range(255));
      n = $urandom_range(3);
      for (i = 0; i < n; i++) put_hdr(sextet_char($urandom_range(63)));
      put_hdr(CH_DOT);
      add_b64(random_claims(), ($urandom_range(3) == 0) ? 5 : 0);
      if ($urandom_range(3) == 0) add_text("==");
      // a few leave out the second dot
      if (kind >= 28) begin
        put_hdr(CH_DOT);
        n = $urandom_range(5);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(4) == 0) put_hdr(8'($urandom_range(255)));
          else put_hdr(sextet_char($urandom_range(63)));
        end
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input bit last);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    take_header_byte(b, last);
  endtask

  task automatic send_header();
    int i;
    for (i = 0; i < hdr.size(); i++) send_byte(hdr[i], i == hdr.size() - 1);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_ids.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    forever begin
      @(negedge clk_i);
      if (rcv_hold > 0) begin
        m_axis_tready_i <= 1'b0;
        rcv_hold = rcv_hold - 1;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    id_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_ids.size() == 0) begin
        report_mismatch("result transfer with nothing pending", m_axis_tdata_o, 64'd0);
      end else begin
        want = pending_ids.pop_front();
        if (m_axis_tdata_o[62:0] != want.user_id)
          report_mismatch("user_id", {1'b0, m_axis_tdata_o[62:0]}, {1'b0, want.user_id});
        if (m_axis_tdata_o[63] != 1'b0)
          report_mismatch("tdata pad bit", {63'd0, m_axis_tdata_o[63]}, 64'd0);
        if (m_axis_tuser_o != want.src)
          report_mismatch("id_source", {62'd0, m_axis_tuser_o}, {62'd0, want.src});
      end
    end
  end

  initial begin
    int i;
    int p;
    int phase_bytes;
    int phase_results;
    mismatches = 0;
    rcv_hold = 0;
    use_typed = 1'b0;
    typed_result = '0;
    snd_idle_pct = 27;
    rcv_idle_pct = 57;
    clear_parse_state();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (i = 0; i < NumRows; i++) begin
      hdr.delete();
      add_text(dir_rows[i].head);
      add_b64(dir_rows[i].claims, 0);
      add_text(dir_rows[i].tail);
      use_typed = dir_rows[i].typed;
      typed_result.user_id = dir_rows[i].user_id;
      typed_result.src = dir_rows[i].src;
      send_header();
    end
    use_typed = 1'b0;

    for (p = 0; p < 3; p++) begin
      drain_results();
      case (p)
        0: begin
          snd_idle_pct = 27;
          rcv_idle_pct = 57;
        end
        1: begin
          snd_idle_pct = 57;
          rcv_idle_pct = 27;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
          // long output stall while bytes keep coming, so the input backs up
          rcv_hold = 300;
        end
      endcase
      phase_bytes = 0;
      phase_results = 0;
      // at least two headers, so a second last byte meets a full output
      while (phase_bytes < 40 || phase_results < 2) begin
        build_random_header();
        phase_bytes += hdr.size();
        phase_results++;
        send_header();
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout, %0d results still pending", pending_ids.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== bearer_token_user_id_extract.f =====
hw/rtl/btuid_pkg.sv
hw/rtl/bearer_token_user_id_extract.sv
hw/rtl/btuid_checker.sv
tb/sv/tb.sv
